/* hw/rtl/ksm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, sizes and codes for the k-way sorted stream merger.
// Depends on nothing; used by the top level and its port checker.
package ksm_pkg;

    // Number of input lists and buffered heads per list. Both are powers of two.
    localparam int MAX_LISTS  = 8;
    localparam int FIFO_DEPTH = 8;

    localparam int LIST_W  = $clog2(MAX_LISTS);
    localparam int SLOT_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int LIVE_W  = $clog2(MAX_LISTS + 1);
    localparam int ADDR_W  = LIST_W + SLOT_W;
    localparam int MEM_DEPTH = MAX_LISTS * FIFO_DEPTH;
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 4;

    // Item kinds.
    localparam logic KIND_PUSH  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_MERGED     = 2'd0;
    localparam logic [1:0] ST_DROP_FULL  = 2'd1;
    localparam logic [1:0] ST_DROP_CLOSE = 2'd2;
    localparam logic [1:0] ST_EMPTY_DONE = 2'd3;

    // Reset value of the active list count.
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(MAX_LISTS);

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_WAIT
    } ksm_state_t;

    // One candidate head in the minimum search.
    typedef struct packed {
        logic              ok;
        logic [LIST_W-1:0] idx;
        logic [DATA_W-1:0] val;
    } ksm_cand_t;

    // Keeps the smaller valid head; on a tie the left (lower index) side wins.
    function automatic ksm_cand_t ksm_min(input ksm_cand_t a, input ksm_cand_t b);
        ksm_cand_t r;
        if (a.ok && (!b.ok || ($signed(a.val) <= $signed(b.val))))
        begin
            r = a;
        end
        else
        begin
            r = b;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/kway_sorted_stream_merger.sv */
`timescale 1ns / 1ps
// Flow: a push or close is taken in S_IDLE and the head check follows next, in S_PICK;
// each merged element then passes S_PICK (minimum select) and, unless it ends the run,
// S_WAIT (head refill from the RAM). A dropped push leaves the block in S_IDLE; any other
// item stalls input until S_IDLE is back; S_PICK emits nothing while a result is stalled.
// Drops are reported at the accept edge. Reset (rst_n, asynchronous) clears counts, closed
// flags, state and the output valid flag at once; the head RAM needs no clearing pass.
// Depends on ksm_pkg.
module kway_sorted_stream_merger (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input item channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [ksm_pkg::LIST_W-1:0]          list_index,
    input  logic signed [ksm_pkg::DATA_W-1:0]   element_value,
    // Result channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ksm_pkg::DATA_W-1:0]   merged_value,
    output logic [ksm_pkg::LIST_W-1:0]          source_list,
    output logic [1:0]                          status,
    output logic                                merge_done,
    output logic                                last_of_run,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ksm_pkg::CFG_W-1:0]           cfg_data
);

    localparam int NL = ksm_pkg::MAX_LISTS;

    ksm_pkg::ksm_state_t state_reg, state_next;

    logic [ksm_pkg::CFG_W-1:0]  active_reg;
    logic [ksm_pkg::CNT_W-1:0]  fill_reg [NL];
    logic [ksm_pkg::SLOT_W-1:0] slot_reg [NL];
    logic [NL-1:0]              closed_reg;
    logic [ksm_pkg::DATA_W-1:0] head_reg [NL];
    logic [ksm_pkg::LIST_W-1:0] li_reg;
    logic [ksm_pkg::LIST_W-1:0] best_reg;

    // Head RAM: one FIFO body per list.
    logic [ksm_pkg::DATA_W-1:0] head_mem [ksm_pkg::MEM_DEPTH];
    logic [ksm_pkg::DATA_W-1:0] mem_rdata_reg;
    logic                       mem_we;
    logic [ksm_pkg::ADDR_W-1:0] mem_waddr;
    logic [ksm_pkg::ADDR_W-1:0] mem_raddr;

    // Output register.
    logic                       out_valid_reg;
    logic [ksm_pkg::DATA_W-1:0] out_value_reg;
    logic [ksm_pkg::LIST_W-1:0] out_src_reg;
    logic [1:0]                 out_status_reg;
    logic                       out_done_reg;
    logic                       out_last_reg;

    logic                       in_accept;
    logic                       out_free;
    logic [ksm_pkg::LIVE_W-1:0] live_n;
    logic [NL-1:0]              active_mask;
    logic                       usable;
    logic                       push_full;
    logic                       drop;
    logic [ksm_pkg::SLOT_W-1:0] wr_slot;

    ksm_pkg::ksm_cand_t         tree [2*NL];
    ksm_pkg::ksm_cand_t         best;
    logic                       any_head;
    logic                       starved;
    logic                       any_after;
    logic                       starved_after;
    logic                       done_after;

    logic                       emit;
    logic                       emit_last;
    logic                       finish_empty;
    logic                       clear_all;

    // Active list count, clamped to 1..MAX_LISTS.
    always_comb
    begin
        if (active_reg == '0)
        begin
            live_n = ksm_pkg::LIVE_W'(1);
        end
        else if (ksm_pkg::LIVE_W'(active_reg) > ksm_pkg::LIVE_W'(NL))
        begin
            live_n = ksm_pkg::LIVE_W'(NL);
        end
        else
        begin
            live_n = ksm_pkg::LIVE_W'(active_reg);
        end
        for (int i = 0; i < NL; i++)
        begin
            active_mask[i] = ksm_pkg::LIVE_W'(i) < live_n;
        end
    end

    // Input handshake and drop decision.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ksm_pkg::S_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;
    assign usable    = active_mask[list_index] && !closed_reg[list_index];
    assign push_full = fill_reg[list_index] >= ksm_pkg::CNT_W'(ksm_pkg::FIFO_DEPTH);
    assign drop      = (kind == ksm_pkg::KIND_PUSH) && (!usable || push_full);
    assign wr_slot   = slot_reg[list_index] + ksm_pkg::SLOT_W'(fill_reg[list_index]);

    // Minimum search over the cached heads as a binary tree, leaves at NL..2*NL-1.
    always_comb
    begin
        tree[0] = '0;
        for (int i = 0; i < NL; i++)
        begin
            tree[NL+i].ok  = active_mask[i] && (fill_reg[i] != '0);
            tree[NL+i].idx = ksm_pkg::LIST_W'(i);
            tree[NL+i].val = head_reg[i];
        end
        for (int n = NL - 1; n >= 1; n--)
        begin
            tree[n] = ksm_pkg::ksm_min(tree[2*n], tree[2*n+1]);
        end
        best = tree[1];
    end

    // List status now and after popping the selected head.
    always_comb
    begin
        logic [ksm_pkg::CNT_W-1:0] f;
        any_head      = 1'b0;
        starved       = 1'b0;
        any_after     = 1'b0;
        starved_after = 1'b0;
        done_after    = 1'b1;
        for (int i = 0; i < NL; i++)
        begin
            f = fill_reg[i];
            if (best.ok && (best.idx == ksm_pkg::LIST_W'(i)))
            begin
                f = fill_reg[i] - ksm_pkg::CNT_W'(1);
            end
            if (active_mask[i])
            begin
                if (fill_reg[i] != '0)
                begin
                    any_head = 1'b1;
                end
                else if (!closed_reg[i])
                begin
                    starved = 1'b1;
                end
                if (f != '0)
                begin
                    any_after  = 1'b1;
                    done_after = 1'b0;
                end
                else if (!closed_reg[i])
                begin
                    starved_after = 1'b1;
                end
                if (!closed_reg[i])
                begin
                    done_after = 1'b0;
                end
            end
        end
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ksm_pkg::S_IDLE:
            begin
                if (in_accept && !drop)
                begin
                    state_next = ksm_pkg::S_PICK;
                end
            end
            ksm_pkg::S_PICK:
            begin
                if (starved)
                begin
                    state_next = ksm_pkg::S_IDLE;
                end
                else if (out_free)
                begin
                    if (!any_head || emit_last)
                    begin
                        state_next = ksm_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = ksm_pkg::S_WAIT;
                    end
                end
            end
            ksm_pkg::S_WAIT:
            begin
                state_next = ksm_pkg::S_PICK;
            end
            default:
            begin
                state_next = ksm_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer: control outputs.
    always_comb
    begin
        emit         = 1'b0;
        finish_empty = 1'b0;
        case (state_reg)
            ksm_pkg::S_PICK:
            begin
                emit         = !starved && any_head && out_free;
                finish_empty = !starved && !any_head && out_free;
            end
            default:
            begin
                emit         = 1'b0;
                finish_empty = 1'b0;
            end
        endcase
        emit_last = emit && (starved_after || !any_after);
        clear_all = finish_empty || (emit_last && done_after);
    end

    // RAM port control: writes on a push, reads the next head of the popped list.
    assign mem_we    = in_accept && !drop && (kind == ksm_pkg::KIND_PUSH);
    assign mem_waddr = {list_index, wr_slot};
    assign mem_raddr = {best.idx, slot_reg[best.idx] + ksm_pkg::SLOT_W'(1)};

    // Head RAM with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            head_mem[mem_waddr] <= element_value;
        end
        mem_rdata_reg <= head_mem[mem_raddr];
    end

    // Sequencer state and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ksm_pkg::S_IDLE;
            active_reg <= ksm_pkg::ACTIVE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
        end
    end

    assign cfg_ready = 1'b1;

    // Per-list bookkeeping: fill counts, read slots and closed flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NL; i++)
            begin
                fill_reg[i] <= '0;
                slot_reg[i] <= '0;
            end
            closed_reg <= '0;
        end
        else if (clear_all)
        begin
            for (int i = 0; i < NL; i++)
            begin
                fill_reg[i] <= '0;
                slot_reg[i] <= '0;
            end
            closed_reg <= '0;
        end
        else if (emit)
        begin
            fill_reg[best.idx] <= fill_reg[best.idx] - ksm_pkg::CNT_W'(1);
            slot_reg[best.idx] <= slot_reg[best.idx] + ksm_pkg::SLOT_W'(1);
        end
        else if (in_accept && !drop)
        begin
            if (kind == ksm_pkg::KIND_PUSH)
            begin
                fill_reg[list_index] <= fill_reg[list_index] + ksm_pkg::CNT_W'(1);
            end
            else if (usable)
            begin
                closed_reg[list_index] <= 1'b1;
            end
        end
    end

    // Cached heads: loaded directly on a push into an empty list, refilled from the RAM
    // in S_WAIT after a pop that leaves entries behind and does not end the run.
    always_ff @(posedge clk)
    begin
        if (mem_we && (fill_reg[list_index] == '0))
        begin
            head_reg[list_index] <= element_value;
        end
        else if ((state_reg == ksm_pkg::S_WAIT) && (fill_reg[best_reg] != '0))
        begin
            head_reg[best_reg] <= mem_rdata_reg;
        end
        if (in_accept)
        begin
            li_reg <= list_index;
        end
        if (emit)
        begin
            best_reg <= best.idx;
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((in_accept && drop) || emit || finish_empty)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept && drop)
        begin
            out_value_reg  <= element_value;
            out_src_reg    <= list_index;
            out_status_reg <= usable ? ksm_pkg::ST_DROP_FULL : ksm_pkg::ST_DROP_CLOSE;
            out_done_reg   <= 1'b0;
            out_last_reg   <= 1'b1;
        end
        else if (emit)
        begin
            out_value_reg  <= best.val;
            out_src_reg    <= best.idx;
            out_status_reg <= ksm_pkg::ST_MERGED;
            out_done_reg   <= emit_last && done_after;
            out_last_reg   <= emit_last;
        end
        else if (finish_empty)
        begin
            out_value_reg  <= '0;
            out_src_reg    <= li_reg;
            out_status_reg <= ksm_pkg::ST_EMPTY_DONE;
            out_done_reg   <= 1'b1;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign merged_value = out_value_reg;
    assign source_list  = out_src_reg;
    assign status       = out_status_reg;
    assign merge_done   = out_done_reg;
    assign last_of_run  = out_last_reg;

endmodule

/* hw/rtl/ksm_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for the k-way sorted stream merger, bound to the top level.
// Depends on ksm_pkg and the top level's port list.
module ksm_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                kind,
    input logic [ksm_pkg::LIST_W-1:0]          list_index,
    input logic signed [ksm_pkg::DATA_W-1:0]   element_value,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [ksm_pkg::DATA_W-1:0]   merged_value,
    input logic [ksm_pkg::LIST_W-1:0]          source_list,
    input logic [1:0]                          status,
    input logic                                merge_done,
    input logic                                last_of_run
);

    // A stalled input transaction keeps its payload.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(kind)
            && $stable(list_index) && $stable(element_value))
        else $error("stalled input changed");

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(merged_value)
            && $stable(source_list) && $stable(status))
        else $error("stalled result changed");

    // The end of a merge always closes the run of results of that item.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && merge_done |-> last_of_run)
        else $error("merge_done without last_of_run");

    // Drops and an empty completion are single results.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ksm_pkg::ST_MERGED) |-> last_of_run)
        else $error("non-merge status not last of run");

    // An empty completion finishes the merge and carries a zero value.
    a_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ksm_pkg::ST_EMPTY_DONE) |-> merge_done && (merged_value == 0))
        else $error("bad empty completion");

endmodule

bind kway_sorted_stream_merger ksm_chk u_ksm_chk (.*);

/* tb/sv/tb_kway_sorted_stream_merger.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the k-way sorted stream merger: a queue-fed driver, a monitor
// and a merge predictor with its own list FIFOs. Depends on ksm_pkg and the merger RTL.
module tb_kway_sorted_stream_merger;

    import ksm_pkg::*;

    localparam int RUN_LIMIT     = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;

    // One input transaction.
    typedef struct {
        logic                     kind;
        logic [LIST_W-1:0]        idx;
        logic signed [DATA_W-1:0] value;
    } merge_item_t;

    // One output transaction.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [LIST_W-1:0]        src;
        logic [1:0]               st;
        logic                     done;
        logic                     last;
    } merge_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     kind = KIND_PUSH;
    logic [LIST_W-1:0]        list_index = '0;
    logic signed [DATA_W-1:0] element_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] merged_value;
    logic [LIST_W-1:0]        source_list;
    logic [1:0]               status;
    logic                     merge_done;
    logic                     last_of_run;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_data = '0;

    // Traffic shaping.
    int   tx_idle_pct = 27;
    int   rx_idle_pct = 79;
    logic rx_hold_go = 1'b0;
    int   rx_hold_left = 0;

    // Stimulus backlog and the results still owed by the block.
    merge_item_t   item_backlog[$];
    merge_result_t merged_due[$];
    int            queued_n = 0;
    int            mismatch_count = 0;

    // Predictor state: one circular FIFO per list plus the closed flags.
    logic [CFG_W-1:0]         active_shadow = ACTIVE_RESET;
    logic signed [DATA_W-1:0] lane_mem [MAX_LISTS][FIFO_DEPTH];
    int                       lane_fill [MAX_LISTS];
    int                       lane_rd [MAX_LISTS];
    bit                       lane_shut [MAX_LISTS];

    kway_sorted_stream_merger dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .list_index    (list_index),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .merged_value  (merged_value),
        .source_list   (source_list),
        .status        (status),
        .merge_done    (merge_done),
        .last_of_run   (last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Effective number of lists for a register value.
    function automatic int live_lists(input logic [CFG_W-1:0] c);
        if (c == 0)
        begin
            return 1;
        end
        if (c > MAX_LISTS)
        begin
            return MAX_LISTS;
        end
        return int'(c);
    endfunction

    function automatic merge_result_t make_result(input logic signed [DATA_W-1:0] v,
                                                  input logic [LIST_W-1:0] src,
                                                  input logic [1:0] st);
        merge_result_t r;
        r.value = v;
        r.src   = src;
        r.st    = st;
        r.done  = 1'b0;
        r.last  = 1'b0;
        return r;
    endfunction

    // Applies one accepted item and queues every result it causes.
    task automatic merge_step(input logic k, input logic [LIST_W-1:0] li,
                              input logic signed [DATA_W-1:0] v);
        merge_result_t            run[$];
        merge_result_t            r;
        int                       n;
        int                       best;
        int                       i;
        bit                       usable;
        bit                       any;
        bit                       starved;
        bit                       finished;
        logic signed [DATA_W-1:0] best_v;
        logic signed [DATA_W-1:0] head;
        n = live_lists(active_shadow);
        usable = (int'(li) < n) && !lane_shut[li];
        if (k == KIND_PUSH)
        begin
            if (!usable || lane_fill[li] >= FIFO_DEPTH)
            begin
                r = make_result(v, li, usable ? ST_DROP_FULL : ST_DROP_CLOSE);
                r.last = 1'b1;
                merged_due.push_back(r);
                return;
            end
            lane_mem[li][(lane_rd[li] + lane_fill[li]) % FIFO_DEPTH] = v;
            lane_fill[li]++;
        end
        else if (usable)
        begin
            lane_shut[li] = 1'b1;
        end

        // Pop the smallest head while no open list is starved.
        while (run.size() < RUN_LIMIT)
        begin
            any = 1'b0;
            starved = 1'b0;
            best = 0;
            best_v = '0;
            for (i = 0; i < n; i++)
            begin
                if (lane_fill[i] == 0)
                begin
                    if (!lane_shut[i])
                    begin
                        starved = 1'b1;
                    end
                end
                else
                begin
                    head = lane_mem[i][lane_rd[i]];
                    if (!any || head < best_v)
                    begin
                        any = 1'b1;
                        best = i;
                        best_v = head;
                    end
                end
            end
            if (starved || !any)
            begin
                break;
            end
            run.push_back(make_result(best_v, LIST_W'(best), ST_MERGED));
            lane_rd[best] = (lane_rd[best] + 1) % FIFO_DEPTH;
            lane_fill[best]--;
        end

        // The merge ends once every active list is closed and drained.
        finished = 1'b1;
        for (i = 0; i < n; i++)
        begin
            if (!lane_shut[i] || lane_fill[i] != 0)
            begin
                finished = 1'b0;
            end
        end
        if (finished)
        begin
            if (run.size() == 0)
            begin
                run.push_back(make_result('0, li, ST_EMPTY_DONE));
            end
            r = run[run.size() - 1];
            r.done = 1'b1;
            run[run.size() - 1] = r;
            for (i = 0; i < MAX_LISTS; i++)
            begin
                lane_fill[i] = 0;
                lane_rd[i] = 0;
                lane_shut[i] = 1'b0;
            end
        end
        if (run.size() > 0)
        begin
            r = run[run.size() - 1];
            r.last = 1'b1;
            run[run.size() - 1] = r;
        end
        foreach (run[j])
        begin
            merged_due.push_back(run[j]);
        end
    endtask

    // Input driver: offers the backlog and holds a stalled transaction steady.
    always @(posedge clk or negedge rst_n)
    begin : input_driver
        merge_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                merge_step(kind, list_index, element_value);
            end
            if (!in_valid || !in_stall)
            begin
                if (item_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    nxt = item_backlog.pop_front();
                    in_valid <= 1'b1;
                    kind <= nxt.kind;
                    list_index <= nxt.idx;
                    element_value <= nxt.value;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the monitor only has to look at it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold_left <= 0;
        end
        else if (rx_hold_go)
        begin
            rx_hold_left <= HOLD_CYCLES;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Output monitor: compares each accepted result with the oldest one owed.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        merge_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (merged_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("unexpected result at %0t:", $time);
                        $display("    value=%0d src=%0d status=%0d done=%0b last=%0b",
                                 merged_value, source_list, status, merge_done, last_of_run);
                    end
                end
                else
                begin
                    want = merged_due.pop_front();
                    if (merged_value !== want.value || source_list !== want.src ||
                        status !== want.st || merge_done !== want.done ||
                        last_of_run !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("result mismatch at %0t:", $time);
                            $display("    expected value=%0d src=%0d status=%0d done=%0b last=%0b",
                                     want.value, want.src, want.st, want.done, want.last);
                            $display("    got value=%0d src=%0d status=%0d done=%0b last=%0b",
                                     merged_value, source_list, status, merge_done, last_of_run);
                        end
                    end
                end
            end
            out_stall <= (rx_hold_left != 0) || ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    task automatic queue_item(input logic k, input logic [LIST_W-1:0] li,
                              input logic signed [DATA_W-1:0] v);
        merge_item_t it;
        it.kind = k;
        it.idx = li;
        it.value = v;
        item_backlog.push_back(it);
        queued_n++;
    endtask

    // One well-formed merge: non-decreasing values per list in random interleaving, each of the
    // first n_lists lists closed after its last push, with a sprinkle of random noise in between.
    task automatic queue_merge(input int n_lists, input int max_len);
        int     left [MAX_LISTS];
        bit     over [MAX_LISTS];
        longint cur [MAX_LISTS];
        int     start_v;
        int     open_n;
        int     i;
        bit     narrow;
        narrow = ($urandom_range(0, 2) == 0);
        open_n = n_lists;
        for (i = 0; i < MAX_LISTS; i++)
        begin
            left[i] = $urandom_range(0, max_len);
            over[i] = (i >= n_lists);
            start_v = $urandom;
            cur[i] = narrow ? longint'($urandom_range(0, 6)) - 3 : longint'(start_v);
        end
        while (open_n > 0)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                queue_item(1'($urandom_range(0, 1)), LIST_W'($urandom_range(0, 7)), $urandom);
            end
            do
            begin
                i = $urandom_range(0, n_lists - 1);
            end
            while (over[i]);
            if (left[i] > 0)
            begin
                queue_item(KIND_PUSH, LIST_W'(i), DATA_W'(cur[i]));
                left[i]--;
                cur[i] += narrow ? $urandom_range(0, 2) : $urandom_range(0, 32'h3fff_ffff);
                if (cur[i] > 64'sd2147483647)
                begin
                    cur[i] = 64'sd2147483647;
                end
            end
            else
            begin
                queue_item(KIND_CLOSE, LIST_W'(i), $urandom);
                over[i] = 1'b1;
                open_n--;
            end
        end
    endtask

    task automatic queue_random(input int quota, input int max_len);
        int target;
        target = queued_n + quota;
        while (queued_n < target)
        begin
            queue_merge(live_lists(active_shadow), max_len);
        end
    endtask

    task automatic set_idle(input int tx_pct, input int rx_pct);
        @(posedge clk);
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    // Blocks until every transaction is accepted and every owed result has come back.
    task automatic wait_quiet();
        while (item_backlog.size() != 0 || in_valid || merged_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic settle();
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the active list count while the block is idle.
    task automatic write_active(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        active_shadow = v;
    endtask

    // Main sequence: directed corner cases, then random merges under changing settings.
    initial
    begin : stimulus
        int i;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Two lists: fill list 0, overflow it, then drain against list 1 with a tie.
        set_idle(27, 79);
        write_active(4'd2);
        queue_item(KIND_PUSH, 3'd0, 32'sh8000_0000);
        queue_item(KIND_PUSH, 3'd0, -32'sd5);
        queue_item(KIND_PUSH, 3'd0, -32'sd1);
        queue_item(KIND_PUSH, 3'd0, 32'sd0);
        queue_item(KIND_PUSH, 3'd0, 32'sd7);
        queue_item(KIND_PUSH, 3'd0, 32'sd100);
        queue_item(KIND_PUSH, 3'd0, 32'sd1000);
        queue_item(KIND_PUSH, 3'd0, 32'sh7fff_ffff);
        queue_item(KIND_PUSH, 3'd0, 32'sd5);
        for (i = 2; i < MAX_LISTS - 1; i++)
        begin
            queue_item(KIND_PUSH, LIST_W'(i), 32'sh5555_5555);
        end
        queue_item(KIND_PUSH, 3'd1, 32'sd7);
        queue_item(KIND_CLOSE, 3'd1, -32'sd1);
        queue_item(KIND_PUSH, 3'd1, 32'shaaaa_aaaa);
        queue_item(KIND_CLOSE, 3'd1, 32'sd0);
        queue_item(KIND_CLOSE, 3'd7, 32'sd0);
        queue_item(KIND_CLOSE, 3'd0, 32'sd0);
        // A merge in which nothing was ever pushed.
        queue_item(KIND_CLOSE, 3'd0, 32'sd0);
        queue_item(KIND_CLOSE, 3'd1, 32'sd0);
        settle();

        // Random merges; the register sweeps its extremes along the way.
        write_active(4'd15);
        queue_random(12, 2);
        settle();
        write_active(4'd0);
        queue_random(12, 3);
        settle();

        set_idle(79, 27);
        write_active(4'd8);
        queue_random(12, 3);
        settle();
        // The sender pauses until the block has delivered everything owed.
        write_active(4'd5);
        queue_random(6, 2);
        wait_quiet();
        queue_random(6, 2);
        settle();

        // No idling; the receiver holds off long enough for the input to back up.
        set_idle(0, 0);
        write_active(4'd8);
        @(posedge clk);
        rx_hold_go <= 1'b1;
        @(posedge clk);
        rx_hold_go <= 1'b0;
        queue_random(12, 3);
        settle();
        write_active(4'd1);
        queue_random(8, 3);
        settle();
        write_active(4'd3);
        queue_random(8, 3);
        settle();

        if (mismatch_count == 0 && merged_due.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ksm_pkg.sv
hw/rtl/kway_sorted_stream_merger.sv
hw/rtl/ksm_chk.sv
tb/sv/tb_kway_sorted_stream_merger.sv
